FILE: hw/rtl/pzw_pkg.sv
// Shared widths, cell types and codes for the neutrino pz W-mass solver.
package pzw_pkg;

  localparam int MOMENTUM_BITS = 20;
  localparam int WSQ_BITS      = 28;
  localparam logic [WSQ_BITS-1:0] WSQ_RESET = 28'd26477199;
  localparam int ROOT_BITS     = MOMENTUM_BITS + 4;

  localparam int SQ2_W   = 2 * MOMENTUM_BITS;
  localparam int ALPHA_W = ((SQ2_W > WSQ_BITS) ? SQ2_W : WSQ_BITS) + 2;
  localparam int A_W     = SQ2_W + 1;
  localparam int APZ_W   = ALPHA_W + MOMENTUM_BITS;
  localparam int DP_W    = 2 * ALPHA_W;
  localparam int DISC_W  = DP_W + SQ2_W;
  localparam int ACC_W   = DISC_W;

  localparam int DIG_W   = 8;
  localparam int DIG_N   = (ALPHA_W + DIG_W - 1) / DIG_W;
  localparam int DIGS_W  = DIG_N * DIG_W;

  localparam int SQ_N    = DISC_W / 2;
  localparam int SQR_W   = SQ_N + 2;
  localparam int SQT_W   = SQ_N + 4;

  localparam int NUM_W   = SQ_N + 2;
  localparam int Q_W     = ROOT_BITS + 1;
  localparam int DIV_W   = ((NUM_W + 1) > (A_W + Q_W + 1)) ? (NUM_W + 1) : (A_W + Q_W + 1);

  localparam int PIPE_N  = 9 + 2 * DIG_N + SQ_N + Q_W;

  localparam int IN_TDATA_W  = ((6 * MOMENTUM_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 + 2 * ROOT_BITS + 7) / 8) * 8;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  mcand;
    logic [DIGS_W-1:0] dig;
  } mul_t;

  typedef struct packed {
    logic [DISC_W-1:0] rad;
    logic [SQR_W-1:0]  rem;
    logic [SQ_N-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [Q_W-1:0]   q;
  } dv_t;

  typedef struct packed {
    logic a_zero;
    logic disc_neg;
    logic disc_zero;
  } case_t;

  typedef struct packed {
    logic signed [A_W-1:0]   a;
    logic signed [APZ_W-1:0] apz;
    logic [SQ2_W-1:0]        e2;
  } s3_t;

  typedef struct packed {
    logic signed [A_W-1:0]   a;
    logic signed [APZ_W-1:0] apz;
  } s4_t;

  typedef struct packed {
    logic signed [A_W-1:0]   a;
    logic signed [APZ_W-1:0] apz;
    case_t                   fl;
  } s5_t;

  typedef struct packed {
    logic  neg_p;
    logic  neg_m;
    logic  big_p;
    logic  big_m;
    case_t fl;
  } s9_t;

  typedef struct packed {
    logic                 sat;
    logic [ROOT_BITS-1:0] val;
  } rsat_t;

endpackage

FILE: hw/rtl/pzw_mul_cell.sv
// One multiplier cell: add the multiplicand times one digit, then shift both on.
module pzw_mul_cell (
  input  logic          clk,
  input  logic          en,
  input  pzw_pkg::mul_t cell_in,
  output pzw_pkg::mul_t cell_out
);

  pzw_pkg::mul_t cell_next;

  always_comb begin
    cell_next.acc   = cell_in.acc
                    + cell_in.mcand * pzw_pkg::ACC_W'(cell_in.dig[pzw_pkg::DIG_W-1:0]);
    cell_next.mcand = cell_in.mcand << pzw_pkg::DIG_W;
    cell_next.dig   = cell_in.dig >> pzw_pkg::DIG_W;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

FILE: hw/rtl/pzw_sqrt_cell.sv
// One square root cell: bring down two radicand bits and settle one root bit.
module pzw_sqrt_cell (
  input  logic         clk,
  input  logic         en,
  input  pzw_pkg::sq_t cell_in,
  output pzw_pkg::sq_t cell_out
);

  pzw_pkg::sq_t                cell_next;
  logic [pzw_pkg::SQT_W-1:0]   part;
  logic [pzw_pkg::SQT_W-1:0]   trial;

  always_comb begin
    part  = {cell_in.rem, cell_in.rad[pzw_pkg::DISC_W-1 -: 2]};
    trial = {2'b00, cell_in.root, 2'b01};
    cell_next.rad = cell_in.rad << 2;
    if (part >= trial) begin
      cell_next.rem  = pzw_pkg::SQR_W'(part - trial);
      cell_next.root = {cell_in.root[pzw_pkg::SQ_N-2:0], 1'b1};
    end else begin
      cell_next.rem  = pzw_pkg::SQR_W'(part);
      cell_next.root = {cell_in.root[pzw_pkg::SQ_N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

FILE: hw/rtl/pzw_div_cell.sv
// One divider cell: trial subtract of the shifted divisor, one quotient bit.
module pzw_div_cell (
  input  logic         clk,
  input  logic         en,
  input  pzw_pkg::dv_t cell_in,
  output pzw_pkg::dv_t cell_out
);

  pzw_pkg::dv_t cell_next;

  always_comb begin
    cell_next.dvs = cell_in.dvs >> 1;
    if (cell_in.rem >= cell_in.dvs) begin
      cell_next.rem = cell_in.rem - cell_in.dvs;
      cell_next.q   = {cell_in.q[pzw_pkg::Q_W-2:0], 1'b1};
    end else begin
      cell_next.rem = cell_in.rem;
      cell_next.q   = {cell_in.q[pzw_pkg::Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

FILE: hw/rtl/neutrino_pz_w_mass_solver.sv
// Top level: W-mass constrained neutrino pz solver, one event per cycle unless stalled.
// Throughput: one event per cycle while not stalled; depth is set by the 62-cell square root chain
// and the two 25-cell divider chains that follow it.
// The whole chain stalls only when its last stage and the output register are both full and m_tready is low.
// Reset: synchronous, clears all valid bits and loads the W mass squared reset value.
module neutrino_pz_w_mass_solver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pzw_pkg::WSQ_BITS-1:0]       cfg_data,   // w_mass_squared
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // lepton_px, lepton_py, lepton_pz, lepton_energy, missing_px, missing_py
  input  logic [pzw_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // root_count, root_plus, root_minus, zero fill
  output logic [pzw_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tuser     // range_flag
);

  localparam int MB = pzw_pkg::MOMENTUM_BITS;
  localparam int RB = pzw_pkg::ROOT_BITS;

  function automatic pzw_pkg::rsat_t root_sat(input logic [pzw_pkg::Q_W-1:0] q,
                                              input logic neg, input logic big);
    pzw_pkg::rsat_t           r;
    logic [pzw_pkg::Q_W-1:0]  lim;
    logic [pzw_pkg::Q_W-1:0]  mag;
    lim = pzw_pkg::Q_W'(1) << (RB - 1);
    if (neg) begin
      r.sat = big || (q > lim);
      mag   = r.sat ? lim : q;
      r.val = RB'(-mag);
    end else begin
      r.sat = big || (q > lim - 1'b1);
      mag   = r.sat ? (lim - 1'b1) : q;
      r.val = RB'(mag);
    end
    return r;
  endfunction

  logic [pzw_pkg::WSQ_BITS-1:0] w_mass_squared;
  logic                         adv;
  logic [pzw_pkg::PIPE_N-1:0]   vld;
  logic                         pv;

  logic signed [MB-1:0] in_lpx, in_lpy, in_lpz, in_mpx, in_mpy;
  logic        [MB-1:0] in_en;

  // stage 1
  logic signed [pzw_pkg::SQ2_W-1:0] xx1, yy1;
  logic        [pzw_pkg::SQ2_W-1:0] pz2_1, e2_1, mx2_1, my2_1;
  logic signed [MB-1:0]             lpz1;
  // stage 2
  logic signed [pzw_pkg::ALPHA_W-1:0] alpha2;
  logic signed [pzw_pkg::A_W-1:0]     a2;
  logic        [pzw_pkg::SQ2_W-1:0]   pt2_2, e2_2;
  logic signed [MB-1:0]               lpz2;
  // stage 3
  logic        [pzw_pkg::ALPHA_W-1:0] amag3;
  logic signed [pzw_pkg::APZ_W-1:0]   apz3;
  logic signed [pzw_pkg::A_W-1:0]     a3;
  logic        [pzw_pkg::SQ2_W-1:0]   pt2_3, e2_3;
  // stage 4
  logic signed [pzw_pkg::DP_W-1:0]    dp4;
  pzw_pkg::s4_t                       s4r;
  logic        [pzw_pkg::SQ2_W-1:0]   e2_4;
  // stage 5
  logic        [pzw_pkg::DISC_W-1:0]  disc5;
  pzw_pkg::s5_t                       s5r;
  // stages 6 to 8
  logic signed [pzw_pkg::NUM_W-1:0]   num_p6, num_m6;
  logic signed [pzw_pkg::A_W-1:0]     a6;
  pzw_pkg::case_t                     fl6, fl7, fl8;
  logic        [pzw_pkg::NUM_W-1:0]   mag_p7, mag_m7;
  logic        [pzw_pkg::A_W-1:0]     amag7;
  logic                               neg_p7, neg_m7, neg_p8, neg_m8;
  logic        [pzw_pkg::DIV_W-1:0]   np8, nm8, d8;
  logic                               big_p8, big_m8;

  pzw_pkg::mul_t m1_c [pzw_pkg::DIG_N+1];
  pzw_pkg::mul_t m2_c [pzw_pkg::DIG_N+1];
  pzw_pkg::mul_t m3_c [pzw_pkg::DIG_N+1];
  pzw_pkg::sq_t  sq_c [pzw_pkg::SQ_N+1];
  pzw_pkg::dv_t  dp_c [pzw_pkg::Q_W+1];
  pzw_pkg::dv_t  dm_c [pzw_pkg::Q_W+1];

  pzw_pkg::s3_t sd3 [pzw_pkg::DIG_N];
  pzw_pkg::s4_t sd4 [pzw_pkg::DIG_N];
  pzw_pkg::s5_t sd5 [pzw_pkg::SQ_N];
  pzw_pkg::s9_t sd9 [pzw_pkg::Q_W];

  pzw_pkg::rsat_t     rp, rm;
  pzw_pkg::s9_t       s9;
  logic [1:0]         p_count, p_count_next, o_count;
  logic [RB-1:0]      p_plus, p_plus_next, o_plus;
  logic [RB-1:0]      p_minus, p_minus_next, o_minus;
  logic               p_flag, p_flag_next, o_flag;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_mass_squared <= pzw_pkg::WSQ_RESET;
    end else if (cfg_valid) begin
      w_mass_squared <= cfg_data;
    end
  end

  // flow control: the whole chain moves together
  assign pv       = vld[pzw_pkg::PIPE_N-1];
  assign adv      = !pv || !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[pzw_pkg::PIPE_N-2:0], s_tvalid};
    end
  end

  assign in_lpx = s_tdata[MB-1:0];
  assign in_lpy = s_tdata[2*MB-1:MB];
  assign in_lpz = s_tdata[3*MB-1:2*MB];
  assign in_en  = s_tdata[4*MB-1:3*MB];
  assign in_mpx = s_tdata[5*MB-1:4*MB];
  assign in_mpy = s_tdata[6*MB-1:5*MB];

  // stages 1 to 3: narrow products, alpha and a, operands for the wide products
  always_ff @(posedge clk) begin
    if (adv) begin
      xx1    <= in_lpx * in_mpx;
      yy1    <= in_lpy * in_mpy;
      pz2_1  <= in_lpz * in_lpz;
      e2_1   <= in_en * in_en;
      mx2_1  <= in_mpx * in_mpx;
      my2_1  <= in_mpy * in_mpy;
      lpz1   <= in_lpz;

      alpha2 <= pzw_pkg::ALPHA_W'(w_mass_squared)
              + ((pzw_pkg::ALPHA_W'(xx1) + pzw_pkg::ALPHA_W'(yy1)) << 1);
      a2     <= pzw_pkg::A_W'(pz2_1) - pzw_pkg::A_W'(e2_1);
      pt2_2  <= mx2_1 + my2_1;
      e2_2   <= e2_1;
      lpz2   <= lpz1;

      amag3  <= alpha2[pzw_pkg::ALPHA_W-1] ? -alpha2 : alpha2;
      apz3   <= alpha2 * lpz2;
      a3     <= a2;
      pt2_3  <= pt2_2;
      e2_3   <= e2_2;
    end
  end

  // a*pt2 and alpha^2
  always_comb begin
    m1_c[0].acc   = '0;
    m1_c[0].mcand = pzw_pkg::ACC_W'(a3);
    m1_c[0].dig   = pzw_pkg::DIGS_W'(pt2_3);
    m2_c[0].acc   = '0;
    m2_c[0].mcand = pzw_pkg::ACC_W'(amag3);
    m2_c[0].dig   = pzw_pkg::DIGS_W'(amag3);
  end

  for (genvar i = 0; i < pzw_pkg::DIG_N; i++) begin : g_mul12
    pzw_mul_cell u_m1 (.clk(clk), .en(adv), .cell_in(m1_c[i]), .cell_out(m1_c[i+1]));
    pzw_mul_cell u_m2 (.clk(clk), .en(adv), .cell_in(m2_c[i]), .cell_out(m2_c[i+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd3[0].a   <= a3;
      sd3[0].apz <= apz3;
      sd3[0].e2  <= e2_3;
      for (int i = 1; i < pzw_pkg::DIG_N; i++) begin
        sd3[i] <= sd3[i-1];
      end
    end
  end

  // stage 4: disc / e^2 = alpha^2 + 4*a*pt2
  always_ff @(posedge clk) begin
    if (adv) begin
      dp4     <= (m1_c[pzw_pkg::DIG_N].acc[pzw_pkg::DP_W-1:0] << 2)
               + m2_c[pzw_pkg::DIG_N].acc[pzw_pkg::DP_W-1:0];
      s4r.a   <= sd3[pzw_pkg::DIG_N-1].a;
      s4r.apz <= sd3[pzw_pkg::DIG_N-1].apz;
      e2_4    <= sd3[pzw_pkg::DIG_N-1].e2;
    end
  end

  always_comb begin
    m3_c[0].acc   = '0;
    m3_c[0].mcand = pzw_pkg::ACC_W'(dp4);
    m3_c[0].dig   = pzw_pkg::DIGS_W'(e2_4);
  end

  for (genvar i = 0; i < pzw_pkg::DIG_N; i++) begin : g_mul3
    pzw_mul_cell u_m3 (.clk(clk), .en(adv), .cell_in(m3_c[i]), .cell_out(m3_c[i+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd4[0] <= s4r;
      for (int i = 1; i < pzw_pkg::DIG_N; i++) begin
        sd4[i] <= sd4[i-1];
      end
    end
  end

  // stage 5: discriminant and the special cases
  always_ff @(posedge clk) begin
    if (adv) begin
      disc5            <= m3_c[pzw_pkg::DIG_N].acc;
      s5r.a            <= sd4[pzw_pkg::DIG_N-1].a;
      s5r.apz          <= sd4[pzw_pkg::DIG_N-1].apz;
      s5r.fl.a_zero    <= (sd4[pzw_pkg::DIG_N-1].a == '0);
      s5r.fl.disc_neg  <= m3_c[pzw_pkg::DIG_N].acc[pzw_pkg::ACC_W-1];
      s5r.fl.disc_zero <= (m3_c[pzw_pkg::DIG_N].acc == '0);
    end
  end

  always_comb begin
    sq_c[0].rad  = disc5;
    sq_c[0].rem  = '0;
    sq_c[0].root = '0;
  end

  for (genvar i = 0; i < pzw_pkg::SQ_N; i++) begin : g_sqrt
    pzw_sqrt_cell u_sq (.clk(clk), .en(adv), .cell_in(sq_c[i]), .cell_out(sq_c[i+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd5[0] <= s5r;
      for (int i = 1; i < pzw_pkg::SQ_N; i++) begin
        sd5[i] <= sd5[i-1];
      end
    end
  end

  // stages 6 to 8: numerators, magnitudes, rounding offsets
  always_ff @(posedge clk) begin
    if (adv) begin
      num_p6 <= pzw_pkg::NUM_W'(sq_c[pzw_pkg::SQ_N].root)
              - pzw_pkg::NUM_W'($signed(sd5[pzw_pkg::SQ_N-1].apz));
      num_m6 <= '0 - pzw_pkg::NUM_W'(sq_c[pzw_pkg::SQ_N].root)
              - pzw_pkg::NUM_W'($signed(sd5[pzw_pkg::SQ_N-1].apz));
      a6     <= sd5[pzw_pkg::SQ_N-1].a;
      fl6    <= sd5[pzw_pkg::SQ_N-1].fl;

      mag_p7 <= num_p6[pzw_pkg::NUM_W-1] ? -num_p6 : num_p6;
      mag_m7 <= num_m6[pzw_pkg::NUM_W-1] ? -num_m6 : num_m6;
      amag7  <= a6[pzw_pkg::A_W-1] ? -a6 : a6;
      neg_p7 <= num_p6[pzw_pkg::NUM_W-1] ^ a6[pzw_pkg::A_W-1];
      neg_m7 <= num_m6[pzw_pkg::NUM_W-1] ^ a6[pzw_pkg::A_W-1];
      fl7    <= fl6;

      // round to nearest: (2n + d) / 2d with d = 2|a|
      np8    <= (pzw_pkg::DIV_W'(mag_p7) << 1) + (pzw_pkg::DIV_W'(amag7) << 1);
      nm8    <= (pzw_pkg::DIV_W'(mag_m7) << 1) + (pzw_pkg::DIV_W'(amag7) << 1);
      d8     <= pzw_pkg::DIV_W'(amag7) << 2;
      neg_p8 <= neg_p7;
      neg_m8 <= neg_m7;
      fl8    <= fl7;
    end
  end

  // a quotient that needs more bits than the chain gives always saturates
  assign big_p8 = ({1'b0, np8} >= ({1'b0, d8} << pzw_pkg::Q_W));
  assign big_m8 = ({1'b0, nm8} >= ({1'b0, d8} << pzw_pkg::Q_W));

  always_comb begin
    dp_c[0].rem = np8;
    dp_c[0].dvs = d8 << (pzw_pkg::Q_W - 1);
    dp_c[0].q   = '0;
    dm_c[0].rem = nm8;
    dm_c[0].dvs = d8 << (pzw_pkg::Q_W - 1);
    dm_c[0].q   = '0;
  end

  for (genvar i = 0; i < pzw_pkg::Q_W; i++) begin : g_div
    pzw_div_cell u_dp (.clk(clk), .en(adv), .cell_in(dp_c[i]), .cell_out(dp_c[i+1]));
    pzw_div_cell u_dm (.clk(clk), .en(adv), .cell_in(dm_c[i]), .cell_out(dm_c[i+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd9[0].neg_p <= neg_p8;
      sd9[0].neg_m <= neg_m8;
      sd9[0].big_p <= big_p8;
      sd9[0].big_m <= big_m8;
      sd9[0].fl    <= fl8;
      for (int i = 1; i < pzw_pkg::Q_W; i++) begin
        sd9[i] <= sd9[i-1];
      end
    end
  end

  // last stage: saturate and pick the reported roots
  always_comb begin
    s9 = sd9[pzw_pkg::Q_W-1];
    rp = root_sat(dp_c[pzw_pkg::Q_W].q, s9.neg_p, s9.big_p);
    rm = root_sat(dm_c[pzw_pkg::Q_W].q, s9.neg_m, s9.big_m);
    p_count_next = pzw_pkg::CNT_NONE;
    p_plus_next  = '0;
    p_minus_next = '0;
    p_flag_next  = 1'b0;
    priority if (s9.fl.a_zero) begin
      p_flag_next = 1'b1;
    end else if (s9.fl.disc_neg) begin
      p_flag_next = 1'b0;
    end else if (s9.fl.disc_zero) begin
      p_count_next = pzw_pkg::CNT_ONE;
      p_plus_next  = rp.val;
      p_flag_next  = rp.sat;
    end else begin
      p_count_next = pzw_pkg::CNT_TWO;
      p_plus_next  = rp.val;
      p_minus_next = rm.val;
      p_flag_next  = rp.sat || rm.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_count <= p_count_next;
      p_plus  <= p_plus_next;
      p_minus <= p_minus_next;
      p_flag  <= p_flag_next;
    end
  end

  // output register: frees the last stage while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      o_count <= p_count;
      o_plus  <= p_plus;
      o_minus <= p_minus;
      o_flag  <= p_flag;
    end
  end

  assign m_tdata = pzw_pkg::OUT_TDATA_W'({o_minus, o_plus, o_count});
  assign m_tuser = o_flag;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (pv && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while the chain is full and the output stalled");

  a_transfer_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted event lost at the chain entry");

  a_single_root: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_count == pzw_pkg::CNT_ONE) |-> (o_minus == '0))
    else $error("second root set for a single solution");

  a_no_root: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_count == pzw_pkg::CNT_NONE) |-> (o_plus == '0 && o_minus == '0))
    else $error("roots set with no solution");

endmodule
